[rtl/rmq_pkg.sv]
// Shared package for the rotation-matrix-to-quaternion block.
// Holds number-format constants, payload structs and the axis table.
// No dependencies.
`timescale 1ns / 1ps

package rmq_pkg;

    localparam int DATA_WIDTH  = 16;
    localparam int FRAC_BITS   = DATA_WIDTH - 2;
    localparam int RAD_W       = DATA_WIDTH + 1;       // positive radicand, raw units
    localparam int NUM_W       = DATA_WIDTH + 1;       // sum or difference of two entries
    localparam int SQ_IN_W     = 2 * DATA_WIDTH - 2;   // radicand scaled for the root
    localparam int ROOT_W      = SQ_IN_W / 2;
    localparam int DEN_W       = ROOT_W + 2;           // 4 * root
    localparam int QUO_W       = 2 * DATA_WIDTH;       // dividend and full quotient
    localparam int QUEUE_DEPTH = 4;

    // cyclic successor of a diagonal index
    localparam logic [1:0] NEXT_AXIS [3] = '{2'd1, 2'd2, 2'd0};

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] m00;
        logic signed [DATA_WIDTH-1:0] m01;
        logic signed [DATA_WIDTH-1:0] m02;
        logic signed [DATA_WIDTH-1:0] m10;
        logic signed [DATA_WIDTH-1:0] m11;
        logic signed [DATA_WIDTH-1:0] m12;
        logic signed [DATA_WIDTH-1:0] m20;
        logic signed [DATA_WIDTH-1:0] m21;
        logic signed [DATA_WIDTH-1:0] m22;
    } mat_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] qw;
        logic signed [DATA_WIDTH-1:0] qx;
        logic signed [DATA_WIDTH-1:0] qy;
        logic signed [DATA_WIDTH-1:0] qz;
        logic                         invalid;
    } quat_t;

    // Classified transaction: which component takes the root, its radicand,
    // and the three numerators of the other components in ascending slot order.
    typedef struct packed {
        logic                  bad;
        logic [1:0]            slot;
        logic [RAD_W-1:0]      rad;
        logic [2:0][NUM_W-1:0] num;
    } cls_t;

    typedef struct packed {
        logic                  bad;
        logic [1:0]            slot;
        logic [2:0][NUM_W-1:0] num;
    } side_t;

    typedef struct packed {
        logic              bad;
        logic [1:0]        slot;
        logic [ROOT_W-1:0] root;
        logic [2:0]        neg;
    } div_side_t;

endpackage

[rtl/rmq_front.sv]
// Front end: classifies one matrix (trace branch or largest diagonal).
// Depends on rmq_pkg.
`timescale 1ns / 1ps

module rmq_front (
    input  rmq_pkg::mat_t mat,
    output rmq_pkg::cls_t cls
);
    import rmq_pkg::*;

    localparam int EW = DATA_WIDTH + 3;
    localparam logic signed [EW-1:0] ONE = EW'(1) << FRAC_BITS;

    logic signed [EW-1:0] mm [3][3];
    logic signed [EW-1:0] trace;
    logic signed [EW-1:0] rad_d;
    logic signed [EW-1:0] rad_sel;
    logic signed [EW-1:0] nsl [4];
    logic [1:0]           i;
    logic [1:0]           j;
    logic [1:0]           k;
    logic [1:0]           slot;
    logic [1:0]           src;
    logic                 bad;

    always_comb
    begin
        mm[0][0] = EW'(mat.m00);
        mm[0][1] = EW'(mat.m01);
        mm[0][2] = EW'(mat.m02);
        mm[1][0] = EW'(mat.m10);
        mm[1][1] = EW'(mat.m11);
        mm[1][2] = EW'(mat.m12);
        mm[2][0] = EW'(mat.m20);
        mm[2][1] = EW'(mat.m21);
        mm[2][2] = EW'(mat.m22);

        trace = mm[0][0] + mm[1][1] + mm[2][2];

        // strict compares: ties keep the lower index
        i = 2'd0;
        if (mm[1][1] > mm[0][0])
        begin
            i = 2'd1;
        end
        if (mm[2][2] > mm[i][i])
        begin
            i = 2'd2;
        end
        j = NEXT_AXIS[i];
        k = NEXT_AXIS[j];
        rad_d = mm[i][i] - mm[j][j] - mm[k][k] + ONE;

        for (int s = 0; s < 4; s++)
        begin
            nsl[s] = '0;
        end

        if (!trace[EW-1] && (trace != '0))
        begin
            slot    = 2'd0;
            rad_sel = trace + ONE;
            bad     = 1'b0;
            nsl[1]  = mm[2][1] - mm[1][2];
            nsl[2]  = mm[0][2] - mm[2][0];
            nsl[3]  = mm[1][0] - mm[0][1];
        end
        else
        begin
            slot    = i + 2'd1;
            rad_sel = rad_d;
            bad     = rad_d[EW-1] || (rad_d == '0);
            nsl[0]  = mm[k][j] - mm[j][k];
            nsl[j + 2'd1] = mm[j][i] + mm[i][j];
            nsl[k + 2'd1] = mm[k][i] + mm[i][k];
        end

        cls.bad  = bad;
        cls.slot = slot;
        cls.rad  = rad_sel[RAD_W-1:0];
        for (int t = 0; t < 3; t++)
        begin
            src = (2'(t) < slot) ? 2'(t) : 2'(t + 1);
            cls.num[t] = nsl[src][NUM_W-1:0];
        end
    end

endmodule

[rtl/rmq_queue.sv]
// Short queue between front end and back end.
// Depends on rmq_pkg.
`timescale 1ns / 1ps

module rmq_queue #(
    parameter int DEPTH = rmq_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rmq_pkg::cls_t item,
    output logic          full,
    input  logic          pop,
    output logic          valid,
    output rmq_pkg::cls_t head
);
    import rmq_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cls_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;

    assign full  = (cnt_reg == CW'(DEPTH));
    assign valid = (cnt_reg != '0);
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        cnt_next = cnt_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= item;
        end
    end

endmodule

[rtl/rmq_sqrt.sv]
// Pipelined digit-by-digit square root, one root bit per stage.
// Gives floor root and remainder. Depends on rmq_pkg.
`timescale 1ns / 1ps

module rmq_sqrt (
    input  logic                         clk,
    input  logic                         en,
    input  logic [rmq_pkg::SQ_IN_W-1:0]  v,
    output logic [rmq_pkg::ROOT_W-1:0]   root,
    output logic [rmq_pkg::ROOT_W+1:0]   rem
);
    import rmq_pkg::*;

    localparam int H   = ROOT_W;
    localparam int RMW = H + 2;

    logic [RMW-1:0]     rem_reg   [H];
    logic [H-1:0]       root_reg  [H];
    logic [SQ_IN_W-1:0] v_reg     [H];
    logic [RMW-1:0]     rem_in    [H];
    logic [H-1:0]       root_in   [H];
    logic [SQ_IN_W-1:0] v_in      [H];
    logic [RMW-1:0]     rem_next  [H];
    logic [H-1:0]       root_next [H];
    logic [SQ_IN_W-1:0] v_next    [H];
    logic [RMW+1:0]     r2        [H];
    logic [RMW+1:0]     trial     [H];

    for (genvar gs = 0; gs < H; gs++)
    begin : g_link
        if (gs == 0)
        begin : g_first
            assign rem_in[gs]  = '0;
            assign root_in[gs] = '0;
            assign v_in[gs]    = v;
        end
        else
        begin : g_rest
            assign rem_in[gs]  = rem_reg[gs-1];
            assign root_in[gs] = root_reg[gs-1];
            assign v_in[gs]    = v_reg[gs-1];
        end
    end

    always_comb
    begin
        for (int s = 0; s < H; s++)
        begin
            r2[s]    = {rem_in[s], v_in[s][SQ_IN_W-1 -: 2]};
            trial[s] = (RMW+2)'({root_in[s], 2'b01});
            if (r2[s] >= trial[s])
            begin
                rem_next[s]  = RMW'(r2[s] - trial[s]);
                root_next[s] = {root_in[s][H-2:0], 1'b1};
            end
            else
            begin
                rem_next[s]  = RMW'(r2[s]);
                root_next[s] = {root_in[s][H-2:0], 1'b0};
            end
            v_next[s] = v_in[s] << 2;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < H; s++)
            begin
                rem_reg[s]  <= rem_next[s];
                root_reg[s] <= root_next[s];
                v_reg[s]    <= v_next[s];
            end
        end
    end

    assign root = root_reg[H-1];
    assign rem  = rem_reg[H-1];

endmodule

[rtl/rmq_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
// Depends on rmq_pkg.
`timescale 1ns / 1ps

module rmq_div (
    input  logic                       clk,
    input  logic                       en,
    input  logic [rmq_pkg::QUO_W-1:0]  num,
    input  logic [rmq_pkg::DEN_W-1:0]  den,
    output logic [rmq_pkg::QUO_W-1:0]  quo
);
    import rmq_pkg::*;

    localparam int S = QUO_W;

    logic [DEN_W-1:0] rem_reg  [S];
    logic [QUO_W-1:0] q_reg    [S];
    logic [QUO_W-1:0] n_reg    [S];
    logic [DEN_W-1:0] d_reg    [S];
    logic [DEN_W-1:0] rem_in   [S];
    logic [QUO_W-1:0] q_in     [S];
    logic [QUO_W-1:0] n_in     [S];
    logic [DEN_W-1:0] d_in     [S];
    logic [DEN_W-1:0] rem_next [S];
    logic [QUO_W-1:0] q_next   [S];
    logic [DEN_W:0]   r2       [S];

    for (genvar gs = 0; gs < S; gs++)
    begin : g_link
        if (gs == 0)
        begin : g_first
            assign rem_in[gs] = '0;
            assign q_in[gs]   = '0;
            assign n_in[gs]   = num;
            assign d_in[gs]   = den;
        end
        else
        begin : g_rest
            assign rem_in[gs] = rem_reg[gs-1];
            assign q_in[gs]   = q_reg[gs-1];
            assign n_in[gs]   = n_reg[gs-1];
            assign d_in[gs]   = d_reg[gs-1];
        end
    end

    always_comb
    begin
        for (int s = 0; s < S; s++)
        begin
            r2[s] = {rem_in[s], n_in[s][QUO_W-1]};
            if (r2[s] >= {1'b0, d_in[s]})
            begin
                rem_next[s] = DEN_W'(r2[s] - {1'b0, d_in[s]});
                q_next[s]   = {q_in[s][QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[s] = DEN_W'(r2[s]);
                q_next[s]   = {q_in[s][QUO_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < S; s++)
            begin
                rem_reg[s] <= rem_next[s];
                q_reg[s]   <= q_next[s];
                n_reg[s]   <= n_in[s] << 1;
                d_reg[s]   <= d_in[s];
            end
        end
    end

    assign quo = q_reg[S-1];

endmodule

[rtl/rmq_back.sv]
// Back end: root, rounding, three quotients, saturation, output register.
// Depends on rmq_pkg, rmq_sqrt, rmq_div.
`timescale 1ns / 1ps

module rmq_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  rmq_pkg::cls_t  q_item,
    output logic           q_pop,
    output logic           quat_valid,
    input  logic           quat_stall,
    output rmq_pkg::quat_t quat
);
    import rmq_pkg::*;

    localparam int SQ_LAT  = ROOT_W;
    localparam int DIV_LAT = QUO_W;
    localparam int PIPE    = SQ_LAT + DIV_LAT + 2;
    localparam logic [QUO_W-1:0] POS_LIM = QUO_W'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
    localparam logic [QUO_W-1:0] NEG_LIM = POS_LIM + 1'b1;

    function automatic logic [DATA_WIDTH-1:0] sat_q(input logic neg,
                                                    input logic [QUO_W-1:0] q);
        logic [QUO_W-1:0] nq;
        nq = QUO_W'(0) - q;
        if (neg)
        begin
            return (q > NEG_LIM) ? NEG_LIM[DATA_WIDTH-1:0] : nq[DATA_WIDTH-1:0];
        end
        return (q > POS_LIM) ? POS_LIM[DATA_WIDTH-1:0] : q[DATA_WIDTH-1:0];
    endfunction

    logic              adv;
    logic [PIPE-1:0]   vld_reg;
    logic              out_valid_reg;
    cls_t              cls_reg;
    side_t             side_reg [SQ_LAT];
    logic [SQ_IN_W-1:0] sq_v;
    logic [ROOT_W-1:0] sq_root;
    logic [ROOT_W+1:0] sq_rem;
    logic [ROOT_W-1:0] root_r;
    side_t             side_end;
    div_side_t         dside_next;
    logic [QUO_W-1:0]  dnum_next [3];
    logic [NUM_W-1:0]  mag [3];
    div_side_t         dside_reg;
    logic [QUO_W-1:0]  dnum_reg [3];
    logic [DEN_W-1:0]  dden_reg;
    div_side_t         dsd_reg [DIV_LAT];
    logic [QUO_W-1:0]  quo [3];
    div_side_t         fin;
    logic [DATA_WIDTH-1:0] satv [3];
    logic [DATA_WIDTH-1:0] q4 [4];
    logic [1:0]        src;
    quat_t             quat_next;
    quat_t             quat_reg;

    // whole back pipeline moves together whenever the output can take a result
    assign adv        = !out_valid_reg || !quat_stall;
    assign q_pop      = adv && q_valid;
    assign quat_valid = out_valid_reg;
    assign quat       = quat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[PIPE-2:0], q_valid};
            out_valid_reg <= vld_reg[PIPE-1];
        end
    end

    assign sq_v = SQ_IN_W'(cls_reg.rad) << (FRAC_BITS - 2);

    rmq_sqrt u_sqrt (
        .clk  (clk),
        .en   (adv),
        .v    (sq_v),
        .root (sq_root),
        .rem  (sq_rem)
    );

    assign side_end = side_reg[SQ_LAT-1];

    always_comb
    begin
        // round to nearest: bump when the remainder exceeds the floor root
        root_r = sq_root + ROOT_W'(sq_rem > (ROOT_W+2)'(sq_root));
        dside_next.bad  = side_end.bad || (root_r == '0);
        dside_next.slot = side_end.slot;
        dside_next.root = root_r;
        for (int t = 0; t < 3; t++)
        begin
            dside_next.neg[t] = side_end.num[t][NUM_W-1];
            mag[t] = dside_next.neg[t] ? NUM_W'(0) - side_end.num[t] : side_end.num[t];
            dnum_next[t] = (QUO_W'(mag[t]) << FRAC_BITS) + QUO_W'({root_r, 1'b0});
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cls_reg     <= q_item;
            side_reg[0] <= '{bad: cls_reg.bad, slot: cls_reg.slot, num: cls_reg.num};
            for (int s = 1; s < SQ_LAT; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end
            dside_reg <= dside_next;
            dden_reg  <= {root_r, 2'b00};
            for (int t = 0; t < 3; t++)
            begin
                dnum_reg[t] <= dnum_next[t];
            end
            dsd_reg[0] <= dside_reg;
            for (int s = 1; s < DIV_LAT; s++)
            begin
                dsd_reg[s] <= dsd_reg[s-1];
            end
            quat_reg <= quat_next;
        end
    end

    for (genvar gt = 0; gt < 3; gt++)
    begin : g_div
        rmq_div u_div (
            .clk (clk),
            .en  (adv),
            .num (dnum_reg[gt]),
            .den (dden_reg),
            .quo (quo[gt])
        );
    end

    assign fin = dsd_reg[DIV_LAT-1];

    always_comb
    begin
        for (int t = 0; t < 3; t++)
        begin
            satv[t] = sat_q(fin.neg[t], quo[t]);
        end
        for (int s = 0; s < 4; s++)
        begin
            src = (2'(s) < fin.slot) ? 2'(s) : 2'(s - 1);
            q4[s] = (2'(s) == fin.slot) ? DATA_WIDTH'(fin.root) : satv[src];
        end
        if (fin.bad)
        begin
            quat_next = '{qw: '0, qx: '0, qy: '0, qz: '0, invalid: 1'b1};
        end
        else
        begin
            quat_next.qw      = q4[0];
            quat_next.qx      = q4[1];
            quat_next.qy      = q4[2];
            quat_next.qz      = q4[3];
            quat_next.invalid = 1'b0;
        end
    end

endmodule

[rtl/rotation_matrix_to_quaternion.sv]
// Top level: rotation matrix (Q1.14) to unit quaternion, front/queue/back.
// Depends on rmq_pkg, rmq_front, rmq_queue, rmq_back.
//
// Usage:
//   Input channel mat/mat_valid/mat_stall carries one 3x3 matrix per
//   transaction; output channel quat/quat_valid/quat_stall carries one
//   quaternion (qw, qx, qy, qz, invalid) per transaction, in input order.
//   Throughput: one transaction per cycle sustained while quat_stall is low.
//   A result passes the queue, the root pipeline (one root bit per stage),
//   rounding, the three parallel dividers (one quotient bit per stage)
//   and the output register on its way from input acceptance to quat_valid.
//   The front end classifies each matrix in the accepting cycle and writes
//   it to a QUEUE_DEPTH-entry queue; mat_stall is high only when that
//   queue is full.
//   While quat_stall holds a valid result, the back pipeline freezes and
//   the queue fills; inputs keep flowing until it is full.
//   Reset (rst_n low, asynchronous) empties queue and pipeline; no result
//   is pending afterwards.
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion #(
    parameter int QUEUE_DEPTH = rmq_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           mat_valid,
    output logic           mat_stall,
    input  rmq_pkg::mat_t  mat,
    output logic           quat_valid,
    input  logic           quat_stall,
    output rmq_pkg::quat_t quat
);
    import rmq_pkg::*;

    cls_t cls;
    cls_t q_head;
    logic q_full;
    logic q_valid;
    logic q_pop;
    logic q_push;

    // classification is combinational on the accepted transaction
    rmq_front u_front (
        .mat (mat),
        .cls (cls)
    );

    assign mat_stall = q_full;
    assign q_push    = mat_valid && !q_full;

    rmq_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .item  (cls),
        .full  (q_full),
        .pop   (q_pop),
        .valid (q_valid),
        .head  (q_head)
    );

    // back end: root, division, saturation, output register
    rmq_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_item     (q_head),
        .q_pop      (q_pop),
        .quat_valid (quat_valid),
        .quat_stall (quat_stall),
        .quat       (quat)
    );

    // an invalid result carries all-zero components
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        quat_valid && quat.invalid |->
            quat.qw == '0 && quat.qx == '0 && quat.qy == '0 && quat.qz == '0)
        else $error("invalid result with nonzero component");

    // a good result is never all-zero: its root component is at least sqrt(2^(FRAC_BITS-2))
    a_valid_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        quat_valid && !quat.invalid |->
            quat.qw != '0 || quat.qx != '0 || quat.qy != '0 || quat.qz != '0)
        else $error("good result with all-zero quaternion");

    // back end must not drain the queue while the output is held
    a_no_pop_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        quat_valid && quat_stall |-> !q_pop)
        else $error("queue popped while output stalled");

endmodule
